[sv/kwp_pkg.sv]
// Package for the module response keyword parser.
// Holds the keyword table, the line layout constants, the step struct and the
// keyword matcher transition function. It depends on nothing else.
package kwp_pkg;

    localparam int LINE_CAPACITY = 128;
    localparam int KEY_COUNT     = 16;
    localparam int KEY_MAX_LEN   = 19;
    localparam int PROG_W        = 5;

    localparam int KEY_DELETE0 = 0;
    localparam int KEY_DELETE1 = 1;
    localparam int KEY_CREATE0 = 2;
    localparam int KEY_CREATE1 = 3;
    localparam int KEY_OPEN    = 4;
    localparam int KEY_WRITE   = 5;
    localparam int KEY_NONE    = 6;
    localparam int KEY_DRIVE   = 7;
    localparam int KEY_STREAM0 = 8;

    localparam int CAPTURE_COUNT = 6;
    localparam logic [7:0] CAPTURE_POS [CAPTURE_COUNT] = '{8'd5, 8'd6, 8'd8, 8'd9, 8'd11, 8'd12};

    localparam logic [7:0] DIGIT_OFFSET = 8'd33;
    localparam logic [7:0] ZERO_FIX     = 8'd90;
    localparam logic [7:0] DRIVE_BASE   = 8'd50;

    localparam logic [8*KEY_MAX_LEN-1:0] KEYS [KEY_COUNT] = '{
        "File deleted", "File not found", "File created", "File already exists",
        "Opened", "Success", "None", "~~,",
        "# 0", "# 1", "# 2", "# 3", "# 4", "# 5", "# 6", "# 7"
    };
    localparam int KEY_LEN [KEY_COUNT] = '{
        12, 14, 12, 19, 6, 7, 4, 3, 3, 3, 3, 3, 3, 3, 3, 3
    };

    typedef struct packed {
        logic       byte_en;
        logic       end_en;
        logic [7:0] data;
    } kwp_step_t;

    // Character i of keyword k; string literals are right-justified.
    function automatic logic [7:0] key_char(input int k, input int i);
        logic [7:0] ch;
        ch = '0;
        if (i >= 0 && i < KEY_LEN[k])
        begin
            ch = KEYS[k][(KEY_LEN[k] - 1 - i) * 8 +: 8];
        end
        return ch;
    endfunction

    // Longest prefix of keyword k that ends the matched prefix p followed by c.
    function automatic logic [PROG_W-1:0] advance(input int k, input logic [PROG_W-1:0] p,
                                                  input logic [7:0] c);
        logic [PROG_W-1:0] best;
        logic              ok;
        int                t;
        best = '0;
        for (int n = 1; n <= KEY_MAX_LEN; n++)
        begin
            if (n <= KEY_LEN[k] && n <= int'(p) + 1)
            begin
                ok = (key_char(k, n - 1) == c);
                for (int i = 0; i < KEY_MAX_LEN - 1; i++)
                begin
                    if (i < n - 1)
                    begin
                        t = int'(p) + 1 - n + i;
                        if (key_char(k, i) != key_char(k, t))
                        begin
                            ok = 1'b0;
                        end
                    end
                end
                if (ok)
                begin
                    best = PROG_W'(n);
                end
            end
        end
        return best;
    endfunction

endpackage

[sv/kwp_line_state.sv]
// Line bookkeeping for the keyword parser: byte position, zero byte, overflow
// and the captured drive bytes. Uses kwp_pkg for the step struct and layout.
module kwp_line_state
(
    input  logic                clk,
    input  logic                rst_n,
    input  kwp_pkg::kwp_step_t  step,
    output logic                match_en,
    output logic [7:0]          captures [kwp_pkg::CAPTURE_COUNT],
    output logic                overflow
);

    logic [7:0] position_reg;
    logic [7:0] position_next;
    logic       zero_seen_reg;
    logic       zero_seen_next;
    logic       overflow_reg;
    logic       overflow_next;
    logic [7:0] capture_reg  [kwp_pkg::CAPTURE_COUNT];
    logic [7:0] capture_next [kwp_pkg::CAPTURE_COUNT];
    logic       in_line;

    assign in_line  = (position_reg < 8'(kwp_pkg::LINE_CAPACITY));
    assign match_en = step.byte_en && in_line && !zero_seen_reg && (step.data != 8'd0);

    always_comb
    begin
        position_next  = position_reg;
        zero_seen_next = zero_seen_reg;
        overflow_next  = overflow_reg;
        capture_next   = capture_reg;
        if (step.end_en)
        begin
            position_next  = '0;
            zero_seen_next = 1'b0;
            overflow_next  = 1'b0;
            for (int s = 0; s < kwp_pkg::CAPTURE_COUNT; s++)
            begin
                capture_next[s] = '0;
            end
        end
        else if (step.byte_en)
        begin
            if (!in_line)
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                position_next = position_reg + 8'd1;
                if (step.data == 8'd0)
                begin
                    zero_seen_next = 1'b1;
                end
                for (int s = 0; s < kwp_pkg::CAPTURE_COUNT; s++)
                begin
                    if (position_reg == kwp_pkg::CAPTURE_POS[s])
                    begin
                        capture_next[s] = step.data;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg  <= '0;
            zero_seen_reg <= 1'b0;
            overflow_reg  <= 1'b0;
            for (int s = 0; s < kwp_pkg::CAPTURE_COUNT; s++)
            begin
                capture_reg[s] <= '0;
            end
        end
        else
        begin
            position_reg  <= position_next;
            zero_seen_reg <= zero_seen_next;
            overflow_reg  <= overflow_next;
            capture_reg   <= capture_next;
        end
    end

    assign captures = capture_reg;
    assign overflow = overflow_reg;

endmodule

[sv/kwp_matcher_bank.sv]
// Sixteen streaming keyword matchers with one matched bit per keyword.
// Uses kwp_pkg for the keyword table and the transition function.
module kwp_matcher_bank
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  kwp_pkg::kwp_step_t            step,
    input  logic                          match_en,
    output logic [kwp_pkg::KEY_COUNT-1:0] matched
);

    logic [kwp_pkg::PROG_W-1:0]    progress_reg  [kwp_pkg::KEY_COUNT];
    logic [kwp_pkg::PROG_W-1:0]    progress_next [kwp_pkg::KEY_COUNT];
    logic [kwp_pkg::KEY_COUNT-1:0] matched_reg;
    logic [kwp_pkg::KEY_COUNT-1:0] matched_next;
    logic [kwp_pkg::PROG_W-1:0]    stepped       [kwp_pkg::KEY_COUNT];

    always_comb
    begin
        progress_next = progress_reg;
        matched_next  = matched_reg;
        for (int k = 0; k < kwp_pkg::KEY_COUNT; k++)
        begin
            stepped[k] = kwp_pkg::advance(k, progress_reg[k], step.data);
            if (step.end_en)
            begin
                progress_next[k] = '0;
                matched_next[k]  = 1'b0;
            end
            else if (match_en && !matched_reg[k])
            begin
                if (stepped[k] >= kwp_pkg::PROG_W'(kwp_pkg::KEY_LEN[k]))
                begin
                    matched_next[k]  = 1'b1;
                    progress_next[k] = '0;
                end
                else
                begin
                    progress_next[k] = stepped[k];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matched_reg <= '0;
            for (int k = 0; k < kwp_pkg::KEY_COUNT; k++)
            begin
                progress_reg[k] <= '0;
            end
        end
        else
        begin
            matched_reg  <= matched_next;
            progress_reg <= progress_next;
        end
    end

    assign matched = matched_reg;

endmodule

[sv/kwp_status.sv]
// Sticky status flags, drive decoding and the result register.
// Uses kwp_pkg for keyword indexes and decoding constants.
module kwp_status
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  kwp_pkg::kwp_step_t            step,
    input  logic [kwp_pkg::KEY_COUNT-1:0] matched,
    input  logic [7:0]                    captures [kwp_pkg::CAPTURE_COUNT],
    input  logic                          overflow,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic [4:0]                    flags,
    output logic [7:0]                    streams,
    output logic                          drive_flag,
    output logic [7:0]                    drives [3],
    output logic                          overflow_flag
);

    logic [4:0] flags_reg;
    logic [4:0] flags_next;
    logic [7:0] streams_reg;
    logic [7:0] streams_next;
    logic       drive_flag_reg;
    logic       drive_flag_next;
    logic [7:0] drive_reg  [3];
    logic [7:0] drive_next [3];
    logic       valid_reg;
    logic       valid_next;
    logic       ovf_reg;
    logic       ovf_next;
    logic [7:0] a_val [3];
    logic [7:0] b_val [3];
    logic [7:0] v_val [3];

    always_comb
    begin
        for (int x = 0; x < 3; x++)
        begin
            a_val[x] = captures[2 * x] - kwp_pkg::DIGIT_OFFSET;
            b_val[x] = captures[2 * x + 1] - kwp_pkg::DIGIT_OFFSET;
            v_val[x] = a_val[x] + b_val[x]
                     + (((b_val[x] == 8'd0) && (a_val[x] != 8'd0)) ? kwp_pkg::ZERO_FIX : 8'd0);
        end
    end

    always_comb
    begin
        flags_next      = flags_reg;
        streams_next    = streams_reg;
        drive_flag_next = drive_flag_reg;
        drive_next      = drive_reg;
        ovf_next        = ovf_reg;
        valid_next      = valid_reg && out_stall;
        if (step.end_en)
        begin
            valid_next = 1'b1;
            ovf_next   = overflow;
            if (matched[kwp_pkg::KEY_DELETE0] || matched[kwp_pkg::KEY_DELETE1])
            begin
                flags_next[0] = 1'b1;
            end
            else if (matched[kwp_pkg::KEY_CREATE0] || matched[kwp_pkg::KEY_CREATE1])
            begin
                flags_next[1] = 1'b1;
            end
            else if (matched[kwp_pkg::KEY_OPEN])
            begin
                flags_next[2] = 1'b1;
            end
            else if (matched[kwp_pkg::KEY_WRITE])
            begin
                flags_next[3] = 1'b1;
            end
            else if (matched[kwp_pkg::KEY_NONE])
            begin
                flags_next[4] = 1'b1;
            end
            streams_next = streams_reg | matched[kwp_pkg::KEY_STREAM0 +: 8];
            if (matched[kwp_pkg::KEY_DRIVE])
            begin
                drive_flag_next = 1'b1;
                for (int x = 0; x < 3; x++)
                begin
                    drive_next[x] = (v_val[x] >> 1) + kwp_pkg::DRIVE_BASE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg      <= '0;
            streams_reg    <= '0;
            drive_flag_reg <= 1'b0;
            valid_reg      <= 1'b0;
            ovf_reg        <= 1'b0;
            for (int x = 0; x < 3; x++)
            begin
                drive_reg[x] <= '0;
            end
        end
        else
        begin
            flags_reg      <= flags_next;
            streams_reg    <= streams_next;
            drive_flag_reg <= drive_flag_next;
            valid_reg      <= valid_next;
            ovf_reg        <= ovf_next;
            drive_reg      <= drive_next;
        end
    end

    assign out_valid     = valid_reg;
    assign flags         = flags_reg;
    assign streams       = streams_reg;
    assign drive_flag    = drive_flag_reg;
    assign drives        = drive_reg;
    assign overflow_flag = ovf_reg;

endmodule

[sv/module_response_keyword_parser.sv]
// Top level of the module response keyword parser.
// Instantiates kwp_line_state, kwp_matcher_bank and kwp_status; uses kwp_pkg.
//
// The block takes one request per clock cycle while in_stall is low. A request
// is held in an input register until it can proceed; there byte requests update
// the keyword matchers and the line in one pass, and an end-of-response request
// loads the result register, so its result passes the input register and the
// result register before it is presented.
// Input stalls only when an end request reaches the input register while an
// earlier result is still held by out_stall.
module module_response_keyword_parser
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       command,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       delete_done,
    output logic       create_done,
    output logic       open_done,
    output logic       write_done,
    output logic       no_streams,
    output logic [7:0] stream_mask,
    output logic       drive_seen,
    output logic [7:0] pan_drive,
    output logic [7:0] tilt_drive,
    output logic [7:0] zoom_drive,
    output logic       line_overflow
);

    logic               stage_valid_reg;
    logic               stage_valid_next;
    logic               stage_cmd_reg;
    logic               stage_cmd_next;
    logic [7:0]         stage_byte_reg;
    logic [7:0]         stage_byte_next;
    logic               stage_go;
    logic               accept;
    kwp_pkg::kwp_step_t step;
    logic               match_en;
    logic [7:0]         captures [kwp_pkg::CAPTURE_COUNT];
    logic               overflow;
    logic [kwp_pkg::KEY_COUNT-1:0] matched;
    logic [4:0]         flags;
    logic [7:0]         drives [3];

    assign stage_go = stage_valid_reg && (!stage_cmd_reg || !out_valid || !out_stall);
    assign in_stall = stage_valid_reg && !stage_go;
    assign accept   = in_valid && !in_stall;

    assign step.byte_en = stage_go && !stage_cmd_reg;
    assign step.end_en  = stage_go && stage_cmd_reg;
    assign step.data    = stage_byte_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg && !stage_go;
        stage_cmd_next   = stage_cmd_reg;
        stage_byte_next  = stage_byte_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
            stage_cmd_next   = command;
            stage_byte_next  = data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_cmd_reg  <= stage_cmd_next;
        stage_byte_reg <= stage_byte_next;
    end

    kwp_line_state u_line
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .match_en (match_en),
        .captures (captures),
        .overflow (overflow)
    );

    kwp_matcher_bank u_match
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .match_en (match_en),
        .matched  (matched)
    );

    kwp_status u_status
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .matched       (matched),
        .captures      (captures),
        .overflow      (overflow),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .flags         (flags),
        .streams       (stream_mask),
        .drive_flag    (drive_seen),
        .drives        (drives),
        .overflow_flag (line_overflow)
    );

    assign delete_done = flags[0];
    assign create_done = flags[1];
    assign open_done   = flags[2];
    assign write_done  = flags[3];
    assign no_streams  = flags[4];
    assign pan_drive   = drives[0];
    assign tilt_drive  = drives[1];
    assign zoom_drive  = drives[2];

    a_stall_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (stage_cmd_reg && out_valid && out_stall))
        else $error("input stalled without a pending end request");

    a_result_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        step.end_en |=> out_valid)
        else $error("end request did not produce a result");

    a_drive_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(drive_seen) |-> $past(step.end_en && matched[kwp_pkg::KEY_DRIVE]))
        else $error("drive flag set outside an end request");

    a_line_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        step.end_en |=> (matched == '0 && !u_line.overflow))
        else $error("line not cleared after end request");

endmodule

[tb/module_response_keyword_parser_tb.sv]
// Self-checking testbench for module_response_keyword_parser.
// Drives byte and end-of-response requests with random gaps and stalls and checks every
// status result against a predictor of its own. Depends on kwp_pkg and the parser RTL.
module module_response_keyword_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 400;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
    } req_t;

    typedef struct packed {
        logic       delete_done;
        logic       create_done;
        logic       open_done;
        logic       write_done;
        logic       no_streams;
        logic [7:0] stream_mask;
        logic       drive_seen;
        logic [7:0] pan_drive;
        logic [7:0] tilt_drive;
        logic [7:0] zoom_drive;
        logic       line_overflow;
    } status_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       command = 1'b0;
    logic [7:0] data_byte = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       delete_done;
    logic       create_done;
    logic       open_done;
    logic       write_done;
    logic       no_streams;
    logic [7:0] stream_mask;
    logic       drive_seen;
    logic [7:0] pan_drive;
    logic [7:0] tilt_drive;
    logic [7:0] zoom_drive;
    logic       line_overflow;

    string kw_text [kwp_pkg::KEY_COUNT] = '{
        "File deleted", "File not found", "File created", "File already exists",
        "Opened", "Success", "None", "~~,",
        "# 0", "# 1", "# 2", "# 3", "# 4", "# 5", "# 6", "# 7"
    };

    req_t    pending_req [$];
    status_t status_due [$];
    int      pushed_cnt = 0;
    int      accepted_cnt = 0;
    int      err_count = 0;
    int      cycle_cnt = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;

    int                         line_pos;
    logic                       zero_seen;
    logic [kwp_pkg::PROG_W-1:0] prog [kwp_pkg::KEY_COUNT];
    logic [15:0]                line_hit;
    logic [7:0]                 cap [kwp_pkg::CAPTURE_COUNT];
    logic                       line_ovf;
    logic                       flag_delete;
    logic                       flag_create;
    logic                       flag_open;
    logic                       flag_write;
    logic                       flag_none;
    logic [7:0]                 flag_stream;
    logic                       flag_drive;
    logic [7:0]                 drive [3];

    module_response_keyword_parser i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .delete_done  (delete_done),
        .create_done  (create_done),
        .open_done    (open_done),
        .write_done   (write_done),
        .no_streams   (no_streams),
        .stream_mask  (stream_mask),
        .drive_seen   (drive_seen),
        .pan_drive    (pan_drive),
        .tilt_drive   (tilt_drive),
        .zoom_drive   (zoom_drive),
        .line_overflow(line_overflow)
    );

    always #5 clk = ~clk;

    function automatic void clear_line();
        line_pos = 0;
        zero_seen = 1'b0;
        line_hit = '0;
        line_ovf = 1'b0;
        for (int k = 0; k < kwp_pkg::KEY_COUNT; k++)
        begin
            prog[k] = '0;
        end
        for (int s = 0; s < kwp_pkg::CAPTURE_COUNT; s++)
        begin
            cap[s] = 8'd0;
        end
    endfunction

    // Longest keyword prefix that ends at the new character.
    function automatic logic [kwp_pkg::PROG_W-1:0] kw_next(int k, logic [kwp_pkg::PROG_W-1:0] p,
                                                           logic [7:0] c);
        int len;
        int n;
        bit ok;
        len = kw_text[k].len();
        n = int'(p) + 1;
        if (n > len)
        begin
            n = len;
        end
        while (n > 0)
        begin
            ok = (8'(kw_text[k][n - 1]) == c);
            for (int i = 0; i < n - 1; i++)
            begin
                if (kw_text[k][int'(p) + 1 - n + i] != kw_text[k][i])
                begin
                    ok = 1'b0;
                end
            end
            if (ok)
            begin
                return kwp_pkg::PROG_W'(n);
            end
            n--;
        end
        return '0;
    endfunction

    function automatic logic [7:0] axis_drive(logic [7:0] hi, logic [7:0] lo);
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] v;
        a = hi - kwp_pkg::DIGIT_OFFSET;
        b = lo - kwp_pkg::DIGIT_OFFSET;
        v = a + b;
        if (b == 8'd0 && a != 8'd0)
        begin
            v = v + kwp_pkg::ZERO_FIX;
        end
        return (v >> 1) + kwp_pkg::DRIVE_BASE;
    endfunction

    function automatic void parse_request(logic cmd, logic [7:0] b);
        status_t st;
        if (!cmd)
        begin
            if (line_pos >= kwp_pkg::LINE_CAPACITY)
            begin
                line_ovf = 1'b1;
            end
            else
            begin
                for (int s = 0; s < kwp_pkg::CAPTURE_COUNT; s++)
                begin
                    if (line_pos == int'(kwp_pkg::CAPTURE_POS[s]))
                    begin
                        cap[s] = b;
                    end
                end
                if (!zero_seen)
                begin
                    if (b == 8'd0)
                    begin
                        zero_seen = 1'b1;
                    end
                    else
                    begin
                        for (int k = 0; k < kwp_pkg::KEY_COUNT; k++)
                        begin
                            if (!line_hit[k])
                            begin
                                prog[k] = kw_next(k, prog[k], b);
                                if (int'(prog[k]) >= kw_text[k].len())
                                begin
                                    line_hit[k] = 1'b1;
                                    prog[k] = '0;
                                end
                            end
                        end
                    end
                end
                line_pos++;
            end
            return;
        end
        if (line_hit[kwp_pkg::KEY_DELETE0] || line_hit[kwp_pkg::KEY_DELETE1])
        begin
            flag_delete = 1'b1;
        end
        else if (line_hit[kwp_pkg::KEY_CREATE0] || line_hit[kwp_pkg::KEY_CREATE1])
        begin
            flag_create = 1'b1;
        end
        else if (line_hit[kwp_pkg::KEY_OPEN])
        begin
            flag_open = 1'b1;
        end
        else if (line_hit[kwp_pkg::KEY_WRITE])
        begin
            flag_write = 1'b1;
        end
        else if (line_hit[kwp_pkg::KEY_NONE])
        begin
            flag_none = 1'b1;
        end
        for (int s = 0; s < 8; s++)
        begin
            if (line_hit[kwp_pkg::KEY_STREAM0 + s])
            begin
                flag_stream[s] = 1'b1;
            end
        end
        if (line_hit[kwp_pkg::KEY_DRIVE])
        begin
            drive[0] = axis_drive(cap[0], cap[1]);
            drive[1] = axis_drive(cap[2], cap[3]);
            drive[2] = axis_drive(cap[4], cap[5]);
            flag_drive = 1'b1;
        end
        st.delete_done = flag_delete;
        st.create_done = flag_create;
        st.open_done = flag_open;
        st.write_done = flag_write;
        st.no_streams = flag_none;
        st.stream_mask = flag_stream;
        st.drive_seen = flag_drive;
        st.pan_drive = drive[0];
        st.tilt_drive = drive[1];
        st.zoom_drive = drive[2];
        st.line_overflow = line_ovf;
        status_due.push_back(st);
        clear_line();
    endfunction

    task automatic push_byte(logic [7:0] b);
        req_t r;
        r.cmd = 1'b0;
        r.data = b;
        pending_req.push_back(r);
        pushed_cnt++;
    endtask

    task automatic push_end();
        req_t r;
        r.cmd = 1'b1;
        r.data = 8'($urandom_range(0, 255));
        pending_req.push_back(r);
        pushed_cnt++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            push_byte(8'(s[i]));
        end
    endtask

    task automatic push_keyword(int k, bit corrupt);
        int         ci;
        logic [7:0] ch;
        ci = -1;
        if (corrupt)
        begin
            ci = $urandom_range(0, kw_text[k].len() - 1);
        end
        for (int i = 0; i < kw_text[k].len(); i++)
        begin
            ch = 8'(kw_text[k][i]);
            if (i == ci)
            begin
                ch = ch ^ (8'd1 << $urandom_range(0, 7));
            end
            push_byte(ch);
        end
    endtask

    function automatic logic [7:0] printable();
        return 8'($urandom_range(32, 126));
    endfunction

    function automatic logic [7:0] digit_char();
        int mode;
        mode = $urandom_range(0, 99);
        if (mode < 70)
        begin
            return 8'($urandom_range(33, 126));
        end
        else if (mode < 85)
        begin
            return kwp_pkg::DIGIT_OFFSET;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic gen_response();
        int         kind;
        int         k;
        int         k2;
        int         s;
        int         n;
        int         cnt;
        logic [7:0] rec [16];
        kind = $urandom_range(0, 99);
        if (kind < 40)
        begin
            repeat ($urandom_range(0, 4)) push_byte(printable());
            k = $urandom_range(0, kwp_pkg::KEY_COUNT - 1);
            if ($urandom_range(0, 6) == 0)
            begin
                n = $urandom_range(1, kw_text[k].len() - 1);
                for (int i = 0; i < n; i++)
                begin
                    push_byte(8'(kw_text[k][i]));
                end
            end
            push_keyword(k, $urandom_range(0, 4) == 0);
            if ($urandom_range(0, 2) == 0)
            begin
                push_keyword($urandom_range(0, kwp_pkg::KEY_COUNT - 1), 1'b0);
            end
            repeat ($urandom_range(0, 3)) push_byte(printable());
        end
        else if (kind < 65)
        begin
            for (int i = 0; i < 16; i++)
            begin
                rec[i] = printable();
            end
            for (int i = 0; i < kwp_pkg::CAPTURE_COUNT; i++)
            begin
                rec[kwp_pkg::CAPTURE_POS[i]] = digit_char();
            end
            s = $urandom_range(0, 3);
            if (s > 0 && $urandom_range(0, 4) == 0)
            begin
                rec[s - 1] = "~";
            end
            rec[s] = "~";
            rec[s + 1] = "~";
            rec[s + 2] = ",";
            n = 13 + $urandom_range(0, 3);
            if ($urandom_range(0, 6) == 0)
            begin
                n = $urandom_range(s + 3, 12);
            end
            if (n > s + 3 && $urandom_range(0, 9) == 0)
            begin
                rec[$urandom_range(s + 3, n - 1)] = 8'd0;
            end
            for (int i = 0; i < n; i++)
            begin
                push_byte(rec[i]);
            end
        end
        else if (kind < 75)
        begin
            repeat ($urandom_range(0, 3)) push_byte(printable());
            if ($urandom_range(0, 1) == 0)
            begin
                push_keyword($urandom_range(0, kwp_pkg::KEY_COUNT - 1), 1'b0);
            end
            push_byte(8'd0);
            push_keyword($urandom_range(0, kwp_pkg::KEY_COUNT - 1), 1'b0);
            repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)));
        end
        else if (kind < 90)
        begin
            repeat ($urandom_range(0, 10)) push_byte(8'($urandom_range(0, 255)));
        end
        else if (kind < 92)
        begin
            k = $urandom_range(0, kwp_pkg::KEY_COUNT - 1);
            n = $urandom_range(kwp_pkg::LINE_CAPACITY + 1, kwp_pkg::LINE_CAPACITY + 12);
            s = $urandom_range(kwp_pkg::LINE_CAPACITY - 20, kwp_pkg::LINE_CAPACITY - 1);
            if ($urandom_range(0, 3) == 0)
            begin
                n = kwp_pkg::LINE_CAPACITY;
                s = kwp_pkg::LINE_CAPACITY - kw_text[k].len();
            end
            cnt = 0;
            while (cnt < s)
            begin
                push_byte(printable());
                cnt++;
            end
            push_keyword(k, 1'b0);
            cnt += kw_text[k].len();
            while (cnt < n)
            begin
                push_byte(printable());
                cnt++;
            end
        end
        else
        begin
            k = $urandom_range(kwp_pkg::KEY_DELETE0, kwp_pkg::KEY_NONE);
            k2 = $urandom_range(kwp_pkg::KEY_DELETE0, kwp_pkg::KEY_NONE);
            push_keyword(k, 1'b0);
            push_byte(printable());
            push_keyword(k2, 1'b0);
            if ($urandom_range(0, 1) == 0)
            begin
                push_keyword($urandom_range(kwp_pkg::KEY_STREAM0, kwp_pkg::KEY_COUNT - 1), 1'b0);
            end
        end
        push_end();
    endtask

    task automatic cmp_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin : driver
        req_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                parse_request(command, data_byte);
                accepted_cnt++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_req.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = pending_req.pop_front();
                    in_valid <= 1'b1;
                    command <= nxt.cmd;
                    data_byte <= nxt.data;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        status_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (status_due.size() == 0)
                begin
                    $error("status result with none outstanding");
                    err_count++;
                end
                else
                begin
                    want = status_due.pop_front();
                    cmp_field("delete_done", want.delete_done, delete_done);
                    cmp_field("create_done", want.create_done, create_done);
                    cmp_field("open_done", want.open_done, open_done);
                    cmp_field("write_done", want.write_done, write_done);
                    cmp_field("no_streams", want.no_streams, no_streams);
                    cmp_field("stream_mask", want.stream_mask, stream_mask);
                    cmp_field("drive_seen", want.drive_seen, drive_seen);
                    cmp_field("pan_drive", want.pan_drive, pan_drive);
                    cmp_field("tilt_drive", want.tilt_drive, tilt_drive);
                    cmp_field("zoom_drive", want.zoom_drive, zoom_drive);
                    cmp_field("line_overflow", want.line_overflow, line_overflow);
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int target;
        clear_line();
        flag_delete = 1'b0;
        flag_create = 1'b0;
        flag_open = 1'b0;
        flag_write = 1'b0;
        flag_none = 1'b0;
        flag_stream = '0;
        flag_drive = 1'b0;
        drive[0] = 8'd0;
        drive[1] = 8'd0;
        drive[2] = 8'd0;
        send_idle_pct = 15;
        recv_idle_pct = 45;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // An empty line, then a record whose axes hit the wrap and zero-low cases,
        // with a zero byte inside the captured area.
        push_end();
        push_text("a~~,x");
        push_byte(8'h21);
        push_byte(8'h21);
        push_byte("x");
        push_byte(8'hFF);
        push_byte(8'h21);
        push_byte("x");
        push_byte(8'h00);
        push_byte(8'hFF);
        push_end();
        push_text("None# 0");
        push_end();
        push_text("~~,");
        push_byte(8'h80);
        push_end();

        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                send_idle_pct = 45;
                recv_idle_pct = 15;
            end
            else if (phase == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            target = pushed_cnt + PHASE_ITEMS;
            while (pushed_cnt < target)
            begin
                gen_response();
            end
            while (accepted_cnt != pushed_cnt) @(posedge clk);
        end

        while (status_due.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
